// File: sv/multi_channel_encoder_tracker_defines.svh
`ifndef MULTI_CHANNEL_ENCODER_TRACKER_DEFINES_SVH
`define MULTI_CHANNEL_ENCODER_TRACKER_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define MCET_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCET_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mcet_pkg.sv
`default_nettype none

package mcet_pkg;

	localparam int ID_W       = 11;
	localparam int ANGLE_W    = 13;
	localparam int SPEED_W    = 16;
	localparam int TURN_W     = 16;
	localparam int POS_W      = 29;
	localparam int ANG_W      = 30;
	localparam int RATE_W     = 14;
	localparam int SETTLE_W   = 8;
	localparam int CNT_W      = SETTLE_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int OUT_DEPTH  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ID_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE  = 1'd1;

	localparam logic [ID_W-1:0]     ID_BASE_RST = 11'd513;
	localparam logic [SETTLE_W-1:0] SETTLE_RST  = 8'd50;
	localparam logic [CNT_W-1:0]    COUNTER_TOP = 9'd256;

	localparam logic signed [RATE_W-1:0] WRAP_LO   = -14'sd7000;
	localparam logic signed [RATE_W-1:0] WRAP_HI   = 14'sd7000;
	localparam logic signed [RATE_W:0]   FULL_TURN = 15'sd8192;

	localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
	localparam logic signed [TURN_W-1:0] TURN_MIN = -16'sh8000;

endpackage

`default_nettype wire

// File: sv/mcet_if.sv
`default_nettype none

interface mcet_frame_if;
	import mcet_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [ID_W-1:0]           frame_id;
	logic [ANGLE_W-1:0]        position_raw;
	logic signed [SPEED_W-1:0] speed_raw;

	modport source (output valid, frame_id, position_raw, speed_raw, input ready);
	modport sink (input valid, frame_id, position_raw, speed_raw, output ready);
endinterface

interface mcet_result_if #(parameter int CH_W = 2);
	import mcet_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CH_W-1:0]           channel;
	logic                      calibrating;
	logic signed [TURN_W-1:0]  round_count;
	logic signed [POS_W-1:0]   position_continuous;
	logic signed [ANG_W-1:0]   angle_counts;
	logic signed [RATE_W-1:0]  rate_unwrapped;
	logic signed [RATE_W-1:0]  rate_filtered;
	logic signed [SPEED_W-1:0] speed_passed;

	modport source (output valid, channel, calibrating, round_count, position_continuous,
		angle_counts, rate_unwrapped, rate_filtered, speed_passed, input ready);
	modport sink (input valid, channel, calibrating, round_count, position_continuous,
		angle_counts, rate_unwrapped, rate_filtered, speed_passed, output ready);
endinterface

`default_nettype wire

// File: sv/multi_channel_encoder_tracker.sv
// Multi-channel encoder tracker.
// frames (sink): one word per feedback frame (frame_id, position_raw, speed_raw).
// results (source): one word per frame whose id falls in id_base .. id_base+CHANNELS-1;
// other ids are consumed silently but still advance the start-up frame counter.
// cfg_we/cfg_index/cfg_data: index 0 is id_base, index 1 is settle_count; write only
// while idle.
// Throughput: one frame per cycle while ready is high. Per-channel state (bias, previous angle,
// turns, running rate sum) sits in a small RAM read at accept and written back in the
// next cycle; the rate history sits in a second RAM read and written the same way. A write
// and a following read of the same entry are bypassed, so back-to-back frames on one
// channel run at full rate.
// A result passes through stage 1, stage 2 and the output queue before it is offered.
// Stall: results drain into a four-word queue; ready drops when queued plus in-flight
// words reach four, so a stalled receiver throttles frames without losing anything.
// Reset: counters, valid bits and history fill flags clear at once; no clearing pass,
// frames may be sent in the first cycle after reset.
`default_nettype none

module multi_channel_encoder_tracker #(
	parameter int RATE_DEPTH = 8,
	parameter int CHANNELS   = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [mcet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mcet_pkg::CFG_DATA_W-1:0]    cfg_data,
	mcet_frame_if.sink                              frames,
	mcet_result_if.source                           results
);
	import mcet_pkg::*;

`include "multi_channel_encoder_tracker_defines.svh"

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_N    = 1 << CH_W;
	localparam int LOG_D   = $clog2(RATE_DEPTH);
	localparam int PTR_W   = (RATE_DEPTH > 1) ? LOG_D : 1;
	localparam int HADDR_W = CH_W + PTR_W;
	localparam int HIST_N  = 1 << HADDR_W;
	localparam int SUM_W   = RATE_W + LOG_D;
	localparam int MAG_W   = SUM_W - 1;
	localparam int SHIFT   = MAG_W + LOG_D;
	localparam int RCP_W   = MAG_W + 2;
	localparam int PROD_W  = MAG_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SHIFT) / RATE_DEPTH + 64'd1);
	localparam int RES_W   = CH_W + 1 + TURN_W + POS_W + ANG_W + RATE_W + RATE_W + SPEED_W;
	localparam int FCNT_W  = $clog2(OUT_DEPTH + 1);
	localparam int OCC_W   = FCNT_W + 1;

	typedef struct packed {
		logic [ANGLE_W-1:0]       bias;
		logic [ANGLE_W-1:0]       prev;
		logic signed [TURN_W-1:0] turns;
		logic signed [SUM_W-1:0]  sum;
	} chan_t;

	// configuration and global state
	logic [ID_W-1:0]     id_base_q;
	logic [SETTLE_W-1:0] settle_q;
	logic [CNT_W-1:0]    frame_cnt_q;
	logic [PTR_W-1:0]    ptr_q [CH_N];
	logic [CH_N-1:0]     wrap_q;
	logic [CH_N-1:0]     chan_vld_q;

	// memories
	chan_t                    chan_mem [CH_N];
	logic signed [RATE_W-1:0] hist_mem [HIST_N];

	// accept stage
	logic                accept;
	logic                match;
	logic [ID_W-1:0]     id_off;
	logic [CH_W-1:0]     ch0;
	logic [CNT_W-1:0]    cnt_next;
	logic                calib0;
	logic [PTR_W-1:0]    ptr0;
	logic [PTR_W-1:0]    ptr_inc;
	logic [HADDR_W-1:0]  haddr0;

	// stage 1
	logic                      v_s1;
	logic                      fwd_chan_s1;
	logic                      fwd_hist_s1;
	logic [CH_W-1:0]           ch_s1;
	logic                      calib_s1;
	logic [ANGLE_W-1:0]        angle_s1;
	logic signed [SPEED_W-1:0] speed_s1;
	logic [HADDR_W-1:0]        haddr_s1;
	logic                      hist_ok_s1;
	logic                      chan_vld_s1;
	chan_t                     chan_rd_s1;
	logic signed [RATE_W-1:0]  hist_rd_s1;
	chan_t                     chan_fwd_q;
	logic signed [RATE_W-1:0]  hist_fwd_q;

	chan_t                     cur;
	chan_t                     chan_new;
	logic signed [RATE_W-1:0]  old_rate;
	logic signed [RATE_W-1:0]  diff;
	logic signed [RATE_W:0]    diff_x;
	logic signed [RATE_W:0]    rate_x;
	logic signed [RATE_W-1:0]  rate1;
	logic                      wrap_up;
	logic                      wrap_dn;
	logic                      hist_we;
	logic signed [TURN_W-1:0]  turns_new;
	logic signed [SUM_W-1:0]   sum_new;

	// stage 2
	logic                      v_s2;
	logic [CH_W-1:0]           ch_s2;
	logic                      calib_s2;
	logic [ANGLE_W-1:0]        angle_s2;
	logic [ANGLE_W-1:0]        bias_s2;
	logic signed [TURN_W-1:0]  turns_s2;
	logic signed [RATE_W-1:0]  rate_s2;
	logic signed [SUM_W-1:0]   sum_s2;
	logic signed [SPEED_W-1:0] speed_s2;

	logic signed [POS_W-1:0]   pos;
	logic signed [ANG_W-1:0]   pos_x;
	logic signed [ANG_W-1:0]   bias_x;
	logic signed [ANG_W-1:0]   ang;
	logic [MAG_W-1:0]          mag;
	logic [PROD_W-1:0]         prod;
	logic signed [RATE_W-1:0]  quot;
	logic signed [RATE_W-1:0]  mean;

	// output queue
	logic [RES_W-1:0]  push_data;
	logic [RES_W-1:0]  res_data;
	logic [FCNT_W-1:0] fifo_cnt;
	logic [OCC_W-1:0]  occ;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= ID_BASE_RST;
			settle_q  <= SETTLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ID_BASE: id_base_q <= cfg_data[ID_W-1:0];
				REG_SETTLE:  settle_q  <= cfg_data[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- accept stage ----------------
	assign occ          = OCC_W'(fifo_cnt) + OCC_W'(v_s1) + OCC_W'(v_s2);
	assign frames.ready = (occ < OCC_W'(OUT_DEPTH));
	assign accept       = frames.valid && frames.ready;

	assign id_off   = frames.frame_id - id_base_q;
	assign match    = (frames.frame_id >= id_base_q) && (id_off < ID_W'(CHANNELS));
	assign ch0      = id_off[CH_W-1:0];
	assign cnt_next = (frame_cnt_q == COUNTER_TOP) ? frame_cnt_q : frame_cnt_q + 1'b1;
	assign calib0   = (cnt_next <= {1'b0, settle_q});
	assign ptr0     = ptr_q[ch0];
	assign ptr_inc  = (ptr0 == PTR_W'(RATE_DEPTH - 1)) ? '0 : ptr0 + 1'b1;
	assign haddr0   = {ch0, ptr0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
			ptr_q       <= '{default: '0};
			wrap_q      <= '0;
		end else if (accept) begin
			frame_cnt_q <= cnt_next;
			if (match && !calib0) begin
				ptr_q[ch0] <= ptr_inc;
				// once the pointer comes round, every history slot holds a real rate
				if (ptr_inc == '0) begin
					wrap_q[ch0] <= 1'b1;
				end
			end
		end
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (v_s1) begin
			chan_mem[ch_s1] <= chan_new;
		end
		chan_rd_s1 <= chan_mem[ch0];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[haddr_s1] <= rate1;
		end
		hist_rd_s1 <= hist_mem[haddr0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_vld_q <= '0;
		end else if (v_s1) begin
			chan_vld_q[ch_s1] <= 1'b1;
		end
	end

	// ---------------- stage 1: read-modify-write ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			fwd_chan_s1 <= 1'b0;
			fwd_hist_s1 <= 1'b0;
		end else begin
			v_s1        <= accept && match;
			// the write below lands on the edge that samples the read: bypass it
			fwd_chan_s1 <= v_s1 && (ch_s1 == ch0);
			fwd_hist_s1 <= hist_we && (haddr_s1 == haddr0);
		end
	end

	always_ff @(posedge clk) begin
		ch_s1       <= ch0;
		calib_s1    <= calib0;
		angle_s1    <= frames.position_raw;
		speed_s1    <= frames.speed_raw;
		haddr_s1    <= haddr0;
		hist_ok_s1  <= wrap_q[ch0];
		chan_vld_s1 <= chan_vld_q[ch0];
		chan_fwd_q  <= chan_new;
		hist_fwd_q  <= rate1;
	end

	always_comb begin
		if (fwd_chan_s1) begin
			cur = chan_fwd_q;
		end else if (chan_vld_s1) begin
			cur = chan_rd_s1;
		end else begin
			cur = '0;
		end
	end

	always_comb begin
		if (!hist_ok_s1) begin
			old_rate = '0;
		end else if (fwd_hist_s1) begin
			old_rate = hist_fwd_q;
		end else begin
			old_rate = hist_rd_s1;
		end
	end

	assign diff    = $signed({1'b0, angle_s1}) - $signed({1'b0, cur.prev});
	assign diff_x  = {diff[RATE_W-1], diff};
	assign wrap_up = (diff < WRAP_LO);
	assign wrap_dn = (diff > WRAP_HI);
	assign rate_x  = wrap_up ? diff_x + FULL_TURN : (wrap_dn ? diff_x - FULL_TURN : diff_x);
	assign rate1   = rate_x[RATE_W-1:0];
	assign hist_we = v_s1 && !calib_s1;

	always_comb begin
		turns_new = cur.turns;
		if (!calib_s1) begin
			if (wrap_up && (cur.turns != TURN_MAX)) begin
				turns_new = cur.turns + 16'sd1;
			end else if (wrap_dn && (cur.turns != TURN_MIN)) begin
				turns_new = cur.turns - 16'sd1;
			end
		end
	end

	// drop the slot being overwritten, add the new rate
	assign sum_new = calib_s1 ? cur.sum : cur.sum - SUM_W'(old_rate) + SUM_W'(rate1);

	always_comb begin
		chan_new.bias  = calib_s1 ? angle_s1 : cur.bias;
		chan_new.prev  = angle_s1;
		chan_new.turns = turns_new;
		chan_new.sum   = sum_new;
	end

	// ---------------- stage 2: format and average ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ch_s2    <= ch_s1;
		calib_s2 <= calib_s1;
		angle_s2 <= angle_s1;
		bias_s2  <= chan_new.bias;
		turns_s2 <= turns_new;
		rate_s2  <= calib_s1 ? '0 : rate1;
		sum_s2   <= sum_new;
		speed_s2 <= speed_s1;
	end

	assign pos    = {turns_s2, angle_s2};
	assign pos_x  = {pos[POS_W-1], pos};
	assign bias_x = {{(ANG_W - ANGLE_W){1'b0}}, bias_s2};
	assign ang    = pos_x - bias_x;

	// truncating mean: divide the magnitude by reciprocal multiply, restore the sign
	assign mag  = sum_s2[SUM_W-1] ? MAG_W'(-sum_s2) : MAG_W'(sum_s2);
	assign prod = PROD_W'(mag) * PROD_W'(RECIP);
	assign quot = RATE_W'(prod >> SHIFT);
	assign mean = sum_s2[SUM_W-1] ? -quot : quot;

	assign push_data = {ch_s2, calib_s2, turns_s2, pos, ang, rate_s2, mean, speed_s2};

	mcet_out_fifo #(
		.W     (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_data (push_data),
		.pop_valid (results.valid),
		.pop_ready (results.ready),
		.pop_data  (res_data),
		.count     (fifo_cnt)
	);

	assign {results.channel, results.calibrating, results.round_count,
		results.position_continuous, results.angle_counts, results.rate_unwrapped,
		results.rate_filtered, results.speed_passed} = res_data;

	// ---------------- assertions ----------------
	`MCET_ASSERT_NOW(a_occ_bound, clk, arst_n, 1'b1, occ <= OCC_W'(OUT_DEPTH), "in-flight words exceed queue depth")
	`MCET_ASSERT_NOW(a_push_room, clk, arst_n, v_s2, (fifo_cnt < FCNT_W'(OUT_DEPTH)) || (results.valid && results.ready), "result pushed into a full queue")
	`MCET_ASSERT_NEXT(a_match_flows, clk, arst_n, accept && match, v_s1, "matched frame did not enter the pipeline")
	`MCET_ASSERT_NEXT(a_cnt_monotone, clk, arst_n, frame_cnt_q == COUNTER_TOP, frame_cnt_q == COUNTER_TOP, "frame counter left saturation")

endmodule

`default_nettype wire

// File: sv/mcet_out_fifo.sv
`default_nettype none

module mcet_out_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic [W-1:0]                   push_data,
	output logic                                pop_valid,
	input  wire logic                           pop_ready,
	output logic [W-1:0]                        pop_data,
	output logic [$clog2(DEPTH + 1)-1:0]        count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign pop_valid = (cnt_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire
